// ----- rtl/stbs_pkg.sv -----
// Shared types and constants for the sorted table binary search block.
// Holds table geometry, controller state encoding and the control/status bundles.
// No dependencies.
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LO_W        = ADDR_W + 1;   // low bound, 0 .. TABLE_DEPTH
    localparam int HI_W        = ADDR_W + 2;   // high bound, signed, -1 .. TABLE_DEPTH-1
    localparam int COUNT_W     = 17;
    localparam int INDEX_W     = 16;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 16;
    localparam int PROBE_W     = 5;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EMIT
    } stbs_state_t;

    typedef struct packed {
        logic write_entry;   // store the accepted beat's value
        logic start_search;  // load key and initial bounds, issue first read
        logic probe;         // compare the returned entry and step the bounds
        logic out_live;      // load result register from this probe's outcome
        logic out_held;      // load result register from the held outcome
    } stbs_cmd_t;

    typedef struct packed {
        logic empty;         // clamped entry_count is zero
        logic finish;        // current probe ends the search
        logic out_free;      // result register can take a new beat this cycle
    } stbs_sts_t;

endpackage

`default_nettype wire

// ----- rtl/stbs_datapath.sv -----
// Datapath: entry table memory, count register, search bounds, probe
// comparator and the result output register. Depends on stbs_pkg.
`default_nettype none

module stbs_datapath
    import stbs_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire stbs_cmd_t                 cmd,
    output stbs_sts_t                      sts,
    input  wire logic                      cfg_we,
    input  wire logic [COUNT_W-1:0]        cfg_count,
    input  wire logic [INDEX_W-1:0]        in_index,
    input  wire logic signed [DATA_W-1:0]  in_value,
    input  wire logic signed [DATA_W-1:0]  in_key,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           out_found,
    output logic [POS_W-1:0]               out_position,
    output logic [PROBE_W-1:0]             out_probes
);

    logic [DATA_W-1:0]          mem [TABLE_DEPTH];
    logic [DATA_W-1:0]          rdata_reg;
    logic [ADDR_W-1:0]          rd_addr;

    logic [COUNT_W-1:0]         count_reg;
    logic signed [DATA_W-1:0]   key_reg;
    logic [LO_W-1:0]            lo_reg, lo_next;
    logic signed [HI_W-1:0]     hi_reg, hi_next;
    logic [ADDR_W-1:0]          mid_reg, mid_next;
    logic [PROBE_W-1:0]         probes_reg, probes_next;
    logic                       found_reg, found_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       out_valid_reg;

    logic [LO_W-1:0]            n_sat, n_m1;
    logic signed [HI_W-1:0]     hi0;
    logic [ADDR_W-1:0]          mid0;

    logic signed [DATA_W-1:0]   val;
    logic                       eq, lt;
    logic [LO_W-1:0]            lo_plus;
    logic signed [HI_W-1:0]     hi_minus;
    logic                       cont_up, cont_dn;
    logic [HI_W-1:0]            sum_up, sum_dn;
    logic [ADDR_W-1:0]          mid_up, mid_dn;
    logic                       wr_ok;

    // Clamp the programmed count to the table depth.
    always_comb begin
        if (count_reg > COUNT_W'(TABLE_DEPTH)) begin
            n_sat = LO_W'(TABLE_DEPTH);
        end else begin
            n_sat = LO_W'(count_reg);
        end
        n_m1 = n_sat - LO_W'(1);
        hi0  = $signed({1'b0, n_sat}) - HI_W'(1);
        mid0 = n_m1[ADDR_W:1];
    end

    // Probe compare, with both possible next midpoints prepared in parallel.
    always_comb begin
        val      = $signed(rdata_reg);
        eq       = (val == key_reg);
        lt       = (val < key_reg);
        lo_plus  = LO_W'({1'b0, mid_reg}) + LO_W'(1);
        hi_minus = $signed(HI_W'({2'b00, mid_reg})) - HI_W'(1);
        cont_up  = $signed({1'b0, lo_plus}) <= hi_reg;
        cont_dn  = $signed({1'b0, lo_reg}) <= hi_minus;
        sum_up   = HI_W'({1'b0, lo_plus}) + $unsigned(hi_reg);
        sum_dn   = HI_W'({1'b0, lo_reg}) + $unsigned(hi_minus);
        mid_up   = sum_up[ADDR_W:1];
        mid_dn   = sum_dn[ADDR_W:1];
    end

    always_comb begin
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        probes_next = probes_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        sts.finish  = 1'b0;
        if (cmd.start_search) begin
            lo_next     = '0;
            hi_next     = hi0;
            mid_next    = mid0;
            probes_next = '0;
            found_next  = 1'b0;
            pos_next    = '0;
        end else if (cmd.probe) begin
            probes_next = probes_reg + PROBE_W'(1);
            if (eq) begin
                found_next = 1'b1;
                pos_next   = POS_W'(mid_reg);
                sts.finish = 1'b1;
            end else if (lt) begin
                lo_next    = lo_plus;
                mid_next   = mid_up;
                sts.finish = !cont_up;
            end else begin
                hi_next    = hi_minus;
                mid_next   = mid_dn;
                sts.finish = !cont_dn;
            end
        end
        sts.empty    = (n_sat == '0);
        sts.out_free = !out_valid_reg || out_ready;
        rd_addr      = mid_next;
    end

    // Table memory: one write port, one registered read port.
    assign wr_ok = cmd.write_entry && ({1'b0, in_index} < (INDEX_W + 1)'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[ADDR_W'(in_index)] <= in_value;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_count;
            end
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_search) begin
            key_reg <= in_key;
        end
        mid_reg    <= mid_next;
        probes_reg <= probes_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

    // Result register: hold the beat until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_live || cmd.out_held) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_live || cmd.out_held) begin
            out_found    <= found_next;
            out_position <= pos_next;
            out_probes   <= probes_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A probe only ever runs with a non-empty window.
    a_probe_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe |-> ($signed({1'b0, lo_reg}) <= hi_reg))
        else $error("probe issued with empty bounds");

    // Search depth is bounded by the address width.
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_probes <= PROBE_W'(ADDR_W + 1)))
        else $error("probe count exceeds table height");

    // A hit implies at least one probe; a miss reports position zero.
    a_hit_probes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_found) |-> (out_probes != '0))
        else $error("hit reported without a probe");

    a_miss_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_found) |-> (out_position == '0))
        else $error("miss reported with nonzero position");

endmodule

`default_nettype wire

// ----- rtl/stbs_controller.sv -----
// Controller: sequences entry writes, search probes and result hand-off.
// Depends on stbs_pkg; drives stbs_datapath through command/status structs.
`default_nettype none

module stbs_controller
    import stbs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      in_op,
    input  wire stbs_sts_t sts,
    output stbs_cmd_t      cmd
);

    stbs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_op == OP_WRITE) begin
                        cmd.write_entry = 1'b1;
                    end else begin
                        cmd.start_search = 1'b1;
                        // Empty table: no probe, hand out the zero result.
                        state_next = sts.empty ? ST_EMIT : ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                cmd.probe = 1'b1;
                if (sts.finish) begin
                    if (sts.out_free) begin
                        cmd.out_live = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_held = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Input is taken only while idle.
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !cmd.start_search && !cmd.write_entry)
        else $error("command issued outside idle");

    // A probe that does not finish keeps the controller probing.
    a_probe_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.probe && !sts.finish) |=> (state_reg == ST_PROBE))
        else $error("search left before finishing");

endmodule

`default_nettype wire

// ----- rtl/sorted_table_binary_search.sv -----
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_controller and stbs_datapath.
//
//  channel  | ports                          | beat carries
//  ---------+--------------------------------+------------------------------------------
//  input    | s_tvalid s_tready s_tuser      | tuser op; tdata index, value, key
//           | s_tdata                        |
//  result   | m_tvalid m_tready m_tuser      | tuser found; tdata position, probe_count
//           | m_tdata                        |
//  config   | cfg_valid cfg_ready cfg_data   | entry_count (always ready)
//
// A write beat stores its value in the table. A search first loads the bounds and
// issues the first table read, then runs one probe per cycle (at most 17 for a
// 65536-entry table), set by the single registered read port of the table:
// each cycle compares the returned entry and issues the next midpoint read.
// An empty table skips probing and emits its result once the output register is free.
// Reset clears control state and entry_count; table contents stay undefined.
// A stalled result beat holds in the output register; the next beat is taken
// meanwhile and a search ending behind it waits until the result is taken.
`default_nettype none

module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 s_tuser,    // [0] op
    input  wire logic [79:0]          s_tdata,    // [15:0] entry_index, [47:16] entry_value,
                                                  // [79:48] search_key

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic                      m_tuser,    // [0] found
    output logic [23:0]               m_tdata,    // [15:0] position, [20:16] probe_count,
                                                  // [23:21] zero

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [COUNT_W-1:0]   cfg_data    // entry_count
);

    stbs_cmd_t          cmd;
    stbs_sts_t          sts;
    logic [POS_W-1:0]   position;
    logic [PROBE_W-1:0] probe_count;

    // Register writes never need to wait; never stall them.
    assign cfg_ready = 1'b1;

    stbs_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    stbs_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_count    (cfg_data),
        .in_index     (s_tdata[15:0]),
        .in_value     ($signed(s_tdata[47:16])),
        .in_key       ($signed(s_tdata[79:48])),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_found    (m_tuser),
        .out_position (position),
        .out_probes   (probe_count)
    );

    // Pack the result beat, zero-filled to a whole byte.
    assign m_tdata = {3'b000, probe_count, position};

endmodule

`default_nettype wire
